FILE: design/bpj_pkg.sv
// Shared types, constants and helper functions for the depth pixel backprojection core.
// Every module of the core imports this package; it has no dependencies of its own.
`timescale 1ns / 1ps

package bpj_pkg;

  // Image geometry and subsampling.
  localparam int unsigned MAX_WIDTH      = 4096;
  localparam int unsigned MAX_HEIGHT     = 4096;
  localparam int unsigned SUBSAMPLE_STEP = 2;

  // Grid test by reciprocal multiplication: quotient = (idx * STEP_RECIP) >> STEP_SHIFT.
  // The ceiling reciprocal is exact for every 12-bit index and a step of up to eight.
  localparam int unsigned STEP_SHIFT   = 24;
  localparam int unsigned STEP_RECIP_W = 25;
  localparam int unsigned STEP_W       = 4;
  localparam int unsigned STEP_RECIP   =
      ((1 << STEP_SHIFT) + SUBSAMPLE_STEP - 1) / SUBSAMPLE_STEP;

  // Field widths.
  localparam int unsigned DEPTH_W = 16;
  localparam int unsigned PIX_W   = 12;
  localparam int unsigned COLOR_W = 8;
  localparam int unsigned CTR_W   = 16;
  localparam int unsigned RECIP_W = 24;
  localparam int unsigned PROD_W  = 40;  // 16 x 24 bit products
  localparam int unsigned TAN_W   = 28;  // rounded offset times reciprocal focal length
  localparam int unsigned Z_W     = 31;
  localparam int unsigned Q_W     = 59;  // TAN_W + Z_W
  localparam int unsigned QR_W    = 43;  // Q_W - 16
  localparam int unsigned COORD_W = 32;

  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 120;

  // Configuration register file.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INV_DEPTH_SCALE = 3'd0,
    CFG_CENTER_X        = 3'd1,
    CFG_CENTER_Y        = 3'd2,
    CFG_INV_FOCAL_X     = 3'd3,
    CFG_INV_FOCAL_Y     = 3'd4
  } cfg_idx_e;

  localparam logic [RECIP_W-1:0] RST_INV_DEPTH_SCALE = 24'd16777;
  localparam logic [CTR_W-1:0]   RST_CENTER_X        = 16'd5120;
  localparam logic [CTR_W-1:0]   RST_CENTER_Y        = 16'd3840;
  localparam logic [RECIP_W-1:0] RST_INV_FOCAL_X     = 24'd31957;
  localparam logic [RECIP_W-1:0] RST_INV_FOCAL_Y     = 24'd31957;

  typedef struct packed {
    logic [RECIP_W-1:0] inv_depth_scale;
    logic [CTR_W-1:0]   center_x;
    logic [CTR_W-1:0]   center_y;
    logic [RECIP_W-1:0] inv_focal_x;
    logic [RECIP_W-1:0] inv_focal_y;
  } cam_cfg_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } color_t;

  typedef struct packed {
    color_t             color;
    logic [PIX_W-1:0]   row;
    logic [PIX_W-1:0]   column;
    logic [DEPTH_W-1:0] depth_value;
  } pixel_t;

  // Signed offset from the principal point, split into sign and magnitude.
  typedef struct packed {
    logic             neg;
    logic [CTR_W-1:0] mag;
  } axis_off_t;

  typedef struct packed {
    color_t             color;
    axis_off_t          off_x;
    axis_off_t          off_y;
    logic [DEPTH_W-1:0] depth_value;
  } offs_t;

  typedef struct packed {
    color_t            color;
    logic              neg_x;
    logic              neg_y;
    logic [Z_W-1:0]    z;
    logic [TAN_W-1:0]  tan_x;
    logic [TAN_W-1:0]  tan_y;
  } scaled_t;

  typedef struct packed {
    color_t                     color;
    logic [Z_W-1:0]             z_pos;
    logic signed [COORD_W-1:0]  y_pos;
    logic signed [COORD_W-1:0]  x_pos;
  } point_t;

  // True when the index is a multiple of the subsample step.
  function automatic logic on_grid(logic [PIX_W-1:0] idx);
    logic [PIX_W+STEP_RECIP_W-1:0] prod;
    logic [PIX_W-1:0]              quo;
    logic [PIX_W+STEP_W-1:0]       back;
    prod = idx * STEP_RECIP_W'(STEP_RECIP);
    quo  = prod[STEP_SHIFT +: PIX_W];
    back = quo * STEP_W'(SUBSAMPLE_STEP);
    return back == {{STEP_W{1'b0}}, idx};
  endfunction

  // Pixel index (integer) against a Q12.4 centre.
  function automatic axis_off_t center_offset(logic [PIX_W-1:0] pix, logic [CTR_W-1:0] ctr);
    axis_off_t        res;
    logic [CTR_W-1:0] p4;
    p4      = {pix, 4'b0000};
    res.neg = p4 < ctr;
    res.mag = res.neg ? (ctr - p4) : (p4 - ctr);
    return res;
  endfunction

  // Applies the sign to a rounded magnitude and saturates to 32 bits.
  function automatic logic signed [COORD_W-1:0] sign_sat(logic [QR_W-1:0] mag, logic neg);
    logic [COORD_W-1:0] m;
    if (neg) begin
      m = (mag > QR_W'(33'h080000000)) ? 32'h80000000 : mag[COORD_W-1:0];
      return COORD_W'(32'd0 - m);
    end else begin
      m = (mag > QR_W'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : mag[COORD_W-1:0];
      return m;
    end
  endfunction

endpackage

FILE: design/depth_pixel_backprojection_core.sv
// Depth pixel backprojection core: one RGB-D pixel request in, at most one colored point out.
// Throughput: one pixel per clock cycle while the output is not stalled, set by the
// six-register pipeline in which every stage holds one item and moves on its own.
// Reset (rst_ni, asynchronous, active low) empties the pipeline and loads camera defaults.
`timescale 1ns / 1ps

module depth_pixel_backprojection_core import bpj_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,

  // Camera configuration write port: register index and data, taken when cfg_we_i is high.
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,

  // Pixel requests.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // depth_value[15:0], column[27:16], row[39:28], blue[47:40], green[55:48], red[63:56]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,

  // Point results.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // x_pos[31:0], y_pos[63:32], z_pos[94:64], point_blue[102:95], point_green[110:103],
  // point_red[118:111], zero pad[119]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // The camera registers. The user must write them only while the pipeline is empty; the
  // block does not enforce this. Every stage reads them directly without a per-item copy.
  cam_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.inv_depth_scale <= RST_INV_DEPTH_SCALE;
      cfg_q.center_x        <= RST_CENTER_X;
      cfg_q.center_y        <= RST_CENTER_Y;
      cfg_q.inv_focal_x     <= RST_INV_FOCAL_X;
      cfg_q.inv_focal_y     <= RST_INV_FOCAL_Y;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_INV_DEPTH_SCALE: cfg_q.inv_depth_scale <= cfg_data_i;
        CFG_CENTER_X:        cfg_q.center_x        <= cfg_data_i[CTR_W-1:0];
        CFG_CENTER_Y:        cfg_q.center_y        <= cfg_data_i[CTR_W-1:0];
        CFG_INV_FOCAL_X:     cfg_q.inv_focal_x     <= cfg_data_i;
        CFG_INV_FOCAL_Y:     cfg_q.inv_focal_y     <= cfg_data_i;
        default: ;  // Indexes past the register list are ignored.
      endcase
    end
  end

  // Unpack the request. The color travels untouched down the whole pipeline.
  pixel_t in_pix;

  always_comb begin
    in_pix.depth_value = s_axis_tdata[15:0];
    in_pix.column      = s_axis_tdata[27:16];
    in_pix.row         = s_axis_tdata[39:28];
    in_pix.color.blue  = s_axis_tdata[47:40];
    in_pix.color.green = s_axis_tdata[55:48];
    in_pix.color.red   = s_axis_tdata[63:56];
  end

  // Three blocks of two stages each. Every stage has its own valid bit and loads when it is
  // empty or its successor is loading, so bubbles are squeezed out and the input keeps
  // flowing while a finished point waits in the output register. Dropped pixels simply
  // leave no valid bit behind after the filter stage.
  logic    offs_valid;
  logic    offs_ready;
  offs_t   offs;
  logic    scaled_valid;
  logic    scaled_ready;
  scaled_t scaled;
  point_t  point;

  bpj_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_pix_i    (in_pix),
    .out_valid_o (offs_valid),
    .out_ready_i (offs_ready),
    .out_offs_o  (offs)
  );

  // z is rounded and saturated here before it feeds the lateral products, as required.
  bpj_scale u_scale (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (offs_valid),
    .in_ready_o   (offs_ready),
    .in_offs_i    (offs),
    .out_valid_o  (scaled_valid),
    .out_ready_i  (scaled_ready),
    .out_scaled_o (scaled)
  );

  // Lateral coordinates round half away from zero: the magnitude is rounded up and the
  // sign of the centre offset is applied last, with saturation to the 32-bit range.
  bpj_project u_project (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (scaled_valid),
    .in_ready_o  (scaled_ready),
    .in_scaled_i (scaled),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_point_o (point)
  );

  assign m_axis_tdata = {1'b0, point.color.red, point.color.green, point.color.blue,
                         point.z_pos, point.y_pos, point.x_pos};

  // The input can only be held off when every stage is full and the output is stalled.
  a_stall_only_on_backpressure: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready)
  ) else $error("input stalled while the output was free");

  // A point at zero depth lies on the optical axis.
  a_zero_depth_on_axis: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (point.z_pos == '0)) |-> (point.x_pos == '0 && point.y_pos == '0)
  ) else $error("nonzero lateral coordinate at zero depth");

  // With a zero horizontal reciprocal focal length every column maps to x of zero.
  a_zero_focal_x: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (cfg_q.inv_focal_x == '0)) |-> (point.x_pos == '0)
  ) else $error("nonzero x with zero reciprocal focal length");

endmodule

FILE: design/bpj_front.sv
// Front end: input register, pixel filter and principal point offsets (two stages).
// Depends on bpj_pkg.
`timescale 1ns / 1ps

module bpj_front import bpj_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cam_cfg_t cfg_i,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  pixel_t   in_pix_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output offs_t    out_offs_o
);

  logic   a_valid_q;
  pixel_t a_pix_q;
  logic   a_ready;
  logic   b_valid_q;
  offs_t  b_offs_q;
  offs_t  b_offs_d;
  logic   b_ready;
  logic   keep;

  assign b_ready    = !b_valid_q || out_ready_i;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_ready_o = a_ready;

  // Pixels off the grid, outside the image or without depth never leave this stage.
  always_comb begin
    keep = on_grid(a_pix_q.column) && on_grid(a_pix_q.row) &&
           (32'(a_pix_q.column) < MAX_WIDTH) && (32'(a_pix_q.row) < MAX_HEIGHT) &&
           (a_pix_q.depth_value != '0);
    b_offs_d.color       = a_pix_q.color;
    b_offs_d.depth_value = a_pix_q.depth_value;
    b_offs_d.off_x       = center_offset(a_pix_q.column, cfg_i.center_x);
    b_offs_d.off_y       = center_offset(a_pix_q.row, cfg_i.center_y);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_ready) a_valid_q <= in_valid_i;
      if (b_ready) b_valid_q <= a_valid_q && keep;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && in_valid_i) a_pix_q <= in_pix_i;
    if (b_ready && a_valid_q) b_offs_q <= b_offs_d;
  end

  assign out_valid_o = b_valid_q;
  assign out_offs_o  = b_offs_q;

endmodule

FILE: design/bpj_scale.sv
// Scaling stages: depth and offset products, then z and lateral rounding (two stages).
// Depends on bpj_pkg.
`timescale 1ns / 1ps

module bpj_scale import bpj_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cam_cfg_t cfg_i,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  offs_t    in_offs_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output scaled_t  out_scaled_o
);

  logic              c_valid_q;
  logic [PROD_W-1:0] c_pz_q;
  logic [PROD_W-1:0] c_px_q;
  logic [PROD_W-1:0] c_py_q;
  logic              c_neg_x_q;
  logic              c_neg_y_q;
  color_t            c_color_q;
  logic              c_ready;

  logic              d_valid_q;
  scaled_t           d_scaled_q;
  scaled_t           d_scaled_d;
  logic              d_ready;

  logic [PROD_W:0]   z_sum;
  logic [PROD_W-1:0] x_sum;
  logic [PROD_W-1:0] y_sum;

  assign d_ready    = !d_valid_q || out_ready_i;
  assign c_ready    = !c_valid_q || d_ready;
  assign in_ready_o = c_ready;

  // Rounding adds; the offset products stay below 2^40 minus 2^24, so no carry is lost.
  always_comb begin
    z_sum = {1'b0, c_pz_q} + (PROD_W+1)'(128);
    x_sum = c_px_q + PROD_W'(2048);
    y_sum = c_py_q + PROD_W'(2048);
    d_scaled_d.color = c_color_q;
    d_scaled_d.neg_x = c_neg_x_q;
    d_scaled_d.neg_y = c_neg_y_q;
    d_scaled_d.z     = z_sum[PROD_W-1] ? {Z_W{1'b1}} : z_sum[8 +: Z_W];
    d_scaled_d.tan_x = x_sum[12 +: TAN_W];
    d_scaled_d.tan_y = y_sum[12 +: TAN_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
    end else begin
      if (c_ready) c_valid_q <= in_valid_i;
      if (d_ready) d_valid_q <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_ready && in_valid_i) begin
      c_pz_q    <= PROD_W'(in_offs_i.depth_value) * PROD_W'(cfg_i.inv_depth_scale);
      c_px_q    <= PROD_W'(in_offs_i.off_x.mag) * PROD_W'(cfg_i.inv_focal_x);
      c_py_q    <= PROD_W'(in_offs_i.off_y.mag) * PROD_W'(cfg_i.inv_focal_y);
      c_neg_x_q <= in_offs_i.off_x.neg;
      c_neg_y_q <= in_offs_i.off_y.neg;
      c_color_q <= in_offs_i.color;
    end
    if (d_ready && c_valid_q) d_scaled_q <= d_scaled_d;
  end

  assign out_valid_o  = d_valid_q;
  assign out_scaled_o = d_scaled_q;

endmodule

FILE: design/bpj_project.sv
// Projection stages: lateral products with z, then rounding, sign and saturation
// into the output register (two stages). Depends on bpj_pkg.
`timescale 1ns / 1ps

module bpj_project import bpj_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  scaled_t in_scaled_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output point_t  out_point_o
);

  logic           e_valid_q;
  logic [Q_W-1:0] e_qx_q;
  logic [Q_W-1:0] e_qy_q;
  logic           e_neg_x_q;
  logic           e_neg_y_q;
  logic [Z_W-1:0] e_z_q;
  color_t         e_color_q;
  logic           e_ready;

  logic           f_valid_q;
  point_t         f_point_q;
  point_t         f_point_d;
  logic           f_ready;

  logic [Q_W-1:0] qx_sum;
  logic [Q_W-1:0] qy_sum;

  assign f_ready    = !f_valid_q || out_ready_i;
  assign e_ready    = !e_valid_q || f_ready;
  assign in_ready_o = e_ready;

  always_comb begin
    qx_sum = e_qx_q + Q_W'(32768);
    qy_sum = e_qy_q + Q_W'(32768);
    f_point_d.color = e_color_q;
    f_point_d.z_pos = e_z_q;
    f_point_d.x_pos = sign_sat(qx_sum[16 +: QR_W], e_neg_x_q);
    f_point_d.y_pos = sign_sat(qy_sum[16 +: QR_W], e_neg_y_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
      f_valid_q <= 1'b0;
    end else begin
      if (e_ready) e_valid_q <= in_valid_i;
      if (f_ready) f_valid_q <= e_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (e_ready && in_valid_i) begin
      e_qx_q    <= Q_W'(in_scaled_i.tan_x) * Q_W'(in_scaled_i.z);
      e_qy_q    <= Q_W'(in_scaled_i.tan_y) * Q_W'(in_scaled_i.z);
      e_neg_x_q <= in_scaled_i.neg_x;
      e_neg_y_q <= in_scaled_i.neg_y;
      e_z_q     <= in_scaled_i.z;
      e_color_q <= in_scaled_i.color;
    end
    if (f_ready && e_valid_q) f_point_q <= f_point_d;
  end

  assign out_valid_o = f_valid_q;
  assign out_point_o = f_point_q;

endmodule

FILE: sim/tb_depth_pixel_backprojection_core.sv
// Self-checking testbench for the depth pixel backprojection core: drives pixel requests,
// predicts every colored point in fixed point and compares each point field by field.
// Depends on bpj_pkg and depth_pixel_backprojection_core only.
`timescale 1ns / 1ps

module tb_depth_pixel_backprojection_core;
  import bpj_pkg::*;

  localparam int unsigned      CLK_HALF_NS   = 6;
  localparam int unsigned      DRAIN_CYCLES  = 16;
  localparam int unsigned      REPORT_LIMIT  = 10;
  localparam longint unsigned  TIMEOUT_NS    = 64'd9_600_000;
  localparam logic [Z_W-1:0]   Z_SAT         = '1;
  localparam int unsigned      POINT_W       = $bits(point_t);
  // Indexes past the register list; writes there must change nothing.
  localparam int unsigned      CFG_IDX_FIRST_UNUSED = 5;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i    = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // depth_value, column, row, blue, green, red from bit 0 up
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // x_pos, y_pos, z_pos, point_blue, point_green, point_red, zero pad from bit 0 up
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // Camera registers as the block should hold them, and the points still owed by it.
  cam_cfg_t cam_model;
  point_t   expected_points[$];
  int       mismatch_count = 0;

  // Idling controls shared by the request driver and the point receiver.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned holdoff_req    = 0;
  int unsigned holdoff_left   = 0;

  depth_pixel_backprojection_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #(CLK_HALF_NS) clk_i = ~clk_i;
  end

  // Lateral coordinate: offset of the pixel from the principal point, scaled by the
  // reciprocal focal length and then by z, rounded half away from zero and saturated.
  function automatic logic [COORD_W-1:0] lateral_offset(logic [PIX_W-1:0] pix,
                                                        logic [CTR_W-1:0] ctr,
                                                        logic [RECIP_W-1:0] inv_f,
                                                        logic [Z_W-1:0] z);
    logic [CTR_W-1:0] p4;
    logic             behind;
    logic [63:0]      span;
    logic [63:0]      tangent;
    logic [63:0]      coord;
    p4      = {pix, 4'b0000};
    behind  = p4 < ctr;
    span    = behind ? 64'(ctr - p4) : 64'(p4 - ctr);
    tangent = (span * 64'(inv_f) + 64'd2048) >> 12;
    coord   = (tangent * 64'(z) + 64'd32768) >> 16;
    if (behind) begin
      if (coord > 64'h8000_0000) coord = 64'h8000_0000;
      return COORD_W'(64'd0 - coord);
    end
    if (coord > 64'h7FFF_FFFF) coord = 64'h7FFF_FFFF;
    return coord[COORD_W-1:0];
  endfunction

  function automatic logic lands_on_cloud(pixel_t px);
    return (px.column % SUBSAMPLE_STEP == 0) && (px.row % SUBSAMPLE_STEP == 0) &&
           (px.column < MAX_WIDTH) && (px.row < MAX_HEIGHT) && (px.depth_value != 0);
  endfunction

  function automatic point_t backproject(pixel_t px);
    point_t         pt;
    logic [63:0]    z_full;
    logic [Z_W-1:0] z;
    z_full   = (64'(px.depth_value) * 64'(cam_model.inv_depth_scale) + 64'd128) >> 8;
    z        = (z_full > 64'(Z_SAT)) ? Z_SAT : z_full[Z_W-1:0];
    pt.x_pos = lateral_offset(px.column, cam_model.center_x, cam_model.inv_focal_x, z);
    pt.y_pos = lateral_offset(px.row, cam_model.center_y, cam_model.inv_focal_y, z);
    pt.z_pos = z;
    pt.color = px.color;
    return pt;
  endfunction

  function automatic pixel_t pixel_at(logic [DEPTH_W-1:0] depth, logic [PIX_W-1:0] col,
                                      logic [PIX_W-1:0] row, logic [COLOR_W-1:0] b,
                                      logic [COLOR_W-1:0] g, logic [COLOR_W-1:0] r);
    pixel_t px;
    px.depth_value = depth;
    px.column      = col;
    px.row         = row;
    px.color.blue  = b;
    px.color.green = g;
    px.color.red   = r;
    return px;
  endfunction

  // Mostly grid-aligned pixels with real depth, so most requests make a point.
  function automatic pixel_t random_pixel();
    pixel_t px;
    px = pixel_t'({$urandom, $urandom});
    if ($urandom_range(99) < 85) begin
      px.column = PIX_W'(px.column - px.column % SUBSAMPLE_STEP);
      px.row    = PIX_W'(px.row - px.row % SUBSAMPLE_STEP);
    end
    case ($urandom_range(9)) inside
      0:       px.depth_value = '0;
      1, 2:    px.depth_value = DEPTH_W'($urandom_range(1, 255));
      default: ;
    endcase
    return px;
  endfunction

  task automatic report_mismatch(string what, logic [COORD_W-1:0] want,
                                 logic [COORD_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("%0t ns: %s mismatch, expected %h, got %h", $realtime, what, want, got);
  endtask

  task automatic check_point(logic [OUT_TDATA_W-1:0] word);
    point_t got;
    point_t want;
    got = word[POINT_W-1:0];
    if (expected_points.size() == 0) begin
      report_mismatch("unrequested point", '0, got.x_pos);
      return;
    end
    want = expected_points.pop_front();
    if (got.x_pos != want.x_pos) report_mismatch("x_pos", want.x_pos, got.x_pos);
    if (got.y_pos != want.y_pos) report_mismatch("y_pos", want.y_pos, got.y_pos);
    if (got.z_pos != want.z_pos)
      report_mismatch("z_pos", COORD_W'(want.z_pos), COORD_W'(got.z_pos));
    if (got.color.blue != want.color.blue)
      report_mismatch("point_blue", COORD_W'(want.color.blue), COORD_W'(got.color.blue));
    if (got.color.green != want.color.green)
      report_mismatch("point_green", COORD_W'(want.color.green), COORD_W'(got.color.green));
    if (got.color.red != want.color.red)
      report_mismatch("point_red", COORD_W'(want.color.red), COORD_W'(got.color.red));
    if (word[OUT_TDATA_W-1:POINT_W] != '0)
      report_mismatch("tdata pad", '0, COORD_W'(word[OUT_TDATA_W-1:POINT_W]));
  endtask

  // Point receiver: random stalls, or a long hold-off when a test asks for one.
  always @(posedge clk_i) begin
    if (holdoff_req != 0) begin
      holdoff_left = holdoff_req;
      holdoff_req  = 0;
    end
    if (holdoff_left != 0) begin
      holdoff_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_point(m_axis_tdata);
  end

  // Offers one pixel request after a random run of idle cycles and books its point once
  // taken. Each cycle is idle with the set percentage until the request goes out.
  task automatic send_pixel(pixel_t px);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= {$urandom, $urandom};
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    do @(posedge clk_i); while (!s_axis_tready);
    if (lands_on_cloud(px)) expected_points.insert(expected_points.size(), backproject(px));
  endtask

  // Lets every owed point come out, then waits out dropped pixels still in the pipeline.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_INV_DEPTH_SCALE: cam_model.inv_depth_scale = data[RECIP_W-1:0];
      CFG_CENTER_X:        cam_model.center_x        = data[CTR_W-1:0];
      CFG_CENTER_Y:        cam_model.center_y        = data[CTR_W-1:0];
      CFG_INV_FOCAL_X:     cam_model.inv_focal_x     = data[RECIP_W-1:0];
      CFG_INV_FOCAL_Y:     cam_model.inv_focal_y     = data[RECIP_W-1:0];
      default:             ;
    endcase
  endtask

  // Reset camera: zero depth, off-grid and corner pixels, the principal point itself.
  task automatic test_directed_pixels();
    send_pixel(pixel_at(16'd0, 12'd0, 12'd0, 8'hFF, 8'hFF, 8'hFF));
    send_pixel(pixel_at(16'hFFFF, 12'd0, 12'd0, 8'hFF, 8'h00, 8'hFF));
    send_pixel(pixel_at(16'd1, 12'd4094, 12'd4094, 8'h00, 8'hFF, 8'h00));
    send_pixel(pixel_at(16'd1000, 12'd1, 12'd0, 8'h12, 8'h34, 8'h56));
    send_pixel(pixel_at(16'd1000, 12'd0, 12'd1, 8'h12, 8'h34, 8'h56));
    send_pixel(pixel_at(16'hFFFF, 12'd4095, 12'd4095, 8'hAA, 8'h55, 8'hAA));
    send_pixel(pixel_at(16'd4000, 12'd320, 12'd240, 8'h01, 8'h02, 8'h03));
    send_pixel(pixel_at(16'd4000, 12'd322, 12'd238, 8'h80, 8'h40, 8'h20));
    send_pixel(pixel_at(16'h8000, 12'd2, 12'd2, 8'h00, 8'h00, 8'h00));
    send_pixel(pixel_at(16'hFFFF, 12'd4094, 12'd0, 8'h7F, 8'hFE, 8'h01));
    send_pixel(pixel_at(16'd0, 12'd4094, 12'd4094, 8'h11, 8'h22, 8'h33));
    wait_idle();
  endtask

  // Register extremes: full saturation both ways, zero scale, masked wide writes and
  // writes to indexes past the register list.
  task automatic test_register_extremes();
    write_reg(CFG_INV_DEPTH_SCALE, 24'hFFFFFF);
    write_reg(CFG_CENTER_X, 24'h000000);
    write_reg(CFG_CENTER_Y, 24'h000000);
    write_reg(CFG_INV_FOCAL_X, 24'hFFFFFF);
    write_reg(CFG_INV_FOCAL_Y, 24'hFFFFFF);
    send_pixel(pixel_at(16'hFFFF, 12'd4094, 12'd4094, 8'hFF, 8'hFF, 8'hFF));
    send_pixel(pixel_at(16'd1, 12'd2, 12'd2, 8'h01, 8'h01, 8'h01));
    send_pixel(pixel_at(16'd256, 12'd0, 12'd0, 8'h02, 8'h02, 8'h02));
    wait_idle();

    write_reg(CFG_CENTER_X, 24'h00FFFF);
    write_reg(CFG_CENTER_Y, 24'h00FFFF);
    send_pixel(pixel_at(16'hFFFF, 12'd0, 12'd0, 8'h03, 8'h04, 8'h05));
    send_pixel(pixel_at(16'hFFFF, 12'd4094, 12'd4094, 8'h06, 8'h07, 8'h08));
    send_pixel(pixel_at(16'd3, 12'd100, 12'd2000, 8'h09, 8'h0A, 8'h0B));
    wait_idle();

    // Zero reciprocals collapse the point onto the origin.
    write_reg(CFG_INV_DEPTH_SCALE, 24'h000000);
    write_reg(CFG_INV_FOCAL_X, 24'h000000);
    write_reg(CFG_INV_FOCAL_Y, 24'h000000);
    send_pixel(pixel_at(16'hFFFF, 12'd4094, 12'd0, 8'hC0, 8'hC1, 8'hC2));
    send_pixel(pixel_at(16'd1, 12'd0, 12'd4094, 8'hC3, 8'hC4, 8'hC5));
    wait_idle();

    // Centers carry junk above bit 15; the unused indexes get junk as well.
    write_reg(CFG_INV_DEPTH_SCALE, 24'd16777);
    write_reg(CFG_CENTER_X, 24'hA5_1400);
    write_reg(CFG_CENTER_Y, 24'hFF_0F00);
    write_reg(CFG_INV_FOCAL_X, 24'd31957);
    write_reg(CFG_INV_FOCAL_Y, 24'd40000);
    for (int i = CFG_IDX_FIRST_UNUSED; i < (1 << CFG_IDX_W); i++)
      write_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
    send_pixel(pixel_at(16'd1500, 12'd640, 12'd0, 8'hE0, 8'hE1, 8'hE2));
    send_pixel(pixel_at(16'd60000, 12'd0, 12'd480, 8'hE3, 8'hE4, 8'hE5));
    wait_idle();
  endtask

  // Random camera and random pixels under one idling pattern.
  task automatic test_random_stream(int unsigned idle_pct, int unsigned stall_pct,
                                    int unsigned count);
    logic [CFG_DATA_W-1:0] scale;
    scale = ($urandom_range(3) == 0) ? CFG_DATA_W'($urandom)
                                     : CFG_DATA_W'($urandom_range(1000, 70000));
    write_reg(CFG_INV_DEPTH_SCALE, scale);
    write_reg(CFG_CENTER_X, CFG_DATA_W'($urandom));
    write_reg(CFG_CENTER_Y, CFG_DATA_W'($urandom));
    write_reg(CFG_INV_FOCAL_X, ($urandom_range(3) == 0) ? CFG_DATA_W'($urandom)
                                      : CFG_DATA_W'($urandom_range(5000, 60000)));
    write_reg(CFG_INV_FOCAL_Y, ($urandom_range(3) == 0) ? CFG_DATA_W'($urandom)
                                      : CFG_DATA_W'($urandom_range(5000, 60000)));
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int unsigned n = 0; n < count; n++) begin
      send_pixel(random_pixel());
    end
    wait_idle();
  endtask

  // The receiver refuses points for a long stretch while requests keep coming, so the
  // pipeline fills and must drop s_axis_tready without losing anything.
  task automatic test_output_holdoff();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    holdoff_req    = 300;
    for (int unsigned n = 0; n < 80; n++) begin
      send_pixel(random_pixel());
    end
    wait_idle();
  endtask

  initial begin
    cam_model.inv_depth_scale = RST_INV_DEPTH_SCALE;
    cam_model.center_x        = RST_CENTER_X;
    cam_model.center_y        = RST_CENTER_Y;
    cam_model.inv_focal_x     = RST_INV_FOCAL_X;
    cam_model.inv_focal_y     = RST_INV_FOCAL_Y;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_pixels();
    test_register_extremes();
    test_random_stream(0, 0, 360);
    test_random_stream(46, 0, 360);
    test_random_stream(0, 46, 360);
    test_random_stream(22, 22, 360);
    test_output_holdoff();

    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: a hung handshake or a point that never shows up ends here.
  initial begin
    #(TIMEOUT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
